// ===== rtl/vprc_pkg.sv =====
// shared types and constants of the vertical plane rectangle corner block
package vprc_pkg;

  // pipeline depths of the direction normalizer
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned NORM_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;

  localparam int unsigned NPTS = 6;

  // point kind codes
  localparam logic [2:0] KIND_C0  = 3'd0;
  localparam logic [2:0] KIND_C1  = 3'd1;
  localparam logic [2:0] KIND_C2  = 3'd2;
  localparam logic [2:0] KIND_C3  = 3'd3;
  localparam logic [2:0] KIND_TOP = 3'd4;
  localparam logic [2:0] KIND_BOT = 3'd5;

  typedef struct packed {
    logic signed [47:0] anchor_x;
    logic signed [47:0] anchor_y;
    logic signed [47:0] anchor_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [47:0] horizontal_extent;
    logic signed [47:0] extent_above;
    logic signed [47:0] extent_below;
  } in_t;

  typedef struct packed {
    logic [2:0]         point_kind;
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
    logic signed [47:0] point_z;
    logic               valid_res;
    logic [46:0]        max_depth;
    logic               last;
  } out_t;

  // one finished item as it waits between front and back
  typedef struct packed {
    logic                  bad;
    logic [NPTS-1:0][47:0] px;
    logic [NPTS-1:0][47:0] py;
    logic [NPTS-1:0][47:0] pz;
    logic [46:0]           depth;
  } entry_t;

endpackage

// ===== rtl/vprc_norm.sv =====
// pipelined normalizer: scale, square sum, square root, reciprocal, Q2.30 unit vector
module vprc_norm import vprc_pkg::*; (
  input  logic             clk_i,
  input  logic [2:0][63:0] mag_i,
  input  logic [2:0]       neg_i,
  output logic [2:0][31:0] unit_o
);

  // largest magnitude and its leading one
  logic [63:0] m;
  logic [5:0]  lead;
  always_comb begin
    m = mag_i[0];
    if (mag_i[1] > m) m = mag_i[1];
    if (mag_i[2] > m) m = mag_i[2];
    lead = 6'd0;
    for (int k = 0; k < 64; k++) begin
      if (m[k]) lead = 6'(k);
    end
  end

  logic [2:0][63:0] n0_mag_q;
  logic [2:0]       n0_neg_q;
  logic [5:0]       n0_lead_q;
  logic             n0_zero_q;
  always_ff @(posedge clk_i) begin
    n0_mag_q  <= mag_i;
    n0_neg_q  <= neg_i;
    n0_lead_q <= lead;
    n0_zero_q <= (m == 64'd0);
  end

  // shift so the largest lies in [2^29, 2^30)
  logic [2:0][29:0] sc;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (n0_lead_q > 6'd29) sc[i] = 30'(n0_mag_q[i] >> (n0_lead_q - 6'd29));
      else sc[i] = 30'(n0_mag_q[i] << (6'd29 - n0_lead_q));
    end
  end

  logic [2:0][29:0] n1_sc_q;
  logic [2:0]       n1_neg_q;
  logic             n1_zero_q;
  always_ff @(posedge clk_i) begin
    n1_sc_q   <= sc;
    n1_neg_q  <= n0_neg_q;
    n1_zero_q <= n0_zero_q;
  end

  // squares
  logic [2:0][59:0] n2_sq_q;
  logic [2:0][29:0] n2_sc_q;
  logic [2:0]       n2_neg_q;
  logic             n2_zero_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      n2_sq_q[i] <= 60'(n1_sc_q[i]) * 60'(n1_sc_q[i]);
    end
    n2_sc_q   <= n1_sc_q;
    n2_neg_q  <= n1_neg_q;
    n2_zero_q <= n1_zero_q;
  end

  // square root, one result bit per stage
  logic [62:0]      sq_rem_q  [SQRT_STEPS+1];
  logic [62:0]      sq_res_q  [SQRT_STEPS+1];
  logic [2:0][29:0] sq_sc_q   [SQRT_STEPS+1];
  logic [2:0]       sq_neg_q  [SQRT_STEPS+1];
  logic             sq_zero_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= 63'(n2_sq_q[0]) + 63'(n2_sq_q[1]) + 63'(n2_sq_q[2]);
    sq_res_q[0]  <= 63'd0;
    sq_sc_q[0]   <= n2_sc_q;
    sq_neg_q[0]  <= n2_neg_q;
    sq_zero_q[0] <= n2_zero_q;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] SBIT = 63'd1 << (60 - 2 * k);
    logic [62:0] trial;
    assign trial = sq_res_q[k] + SBIT;
    always_ff @(posedge clk_i) begin
      if (sq_rem_q[k] >= trial) begin
        sq_rem_q[k+1] <= sq_rem_q[k] - trial;
        sq_res_q[k+1] <= (sq_res_q[k] >> 1) + SBIT;
      end else begin
        sq_rem_q[k+1] <= sq_rem_q[k];
        sq_res_q[k+1] <= sq_res_q[k] >> 1;
      end
      sq_sc_q[k+1]   <= sq_sc_q[k];
      sq_neg_q[k+1]  <= sq_neg_q[k];
      sq_zero_q[k+1] <= sq_zero_q[k];
    end
  end

  // reciprocal 2^61 / len, one quotient bit per stage
  logic [31:0]      dv_rem_q  [1:DIV_STEPS];
  logic [32:0]      dv_quo_q  [1:DIV_STEPS];
  logic [31:0]      dv_len_q  [1:DIV_STEPS];
  logic [2:0][29:0] dv_sc_q   [1:DIV_STEPS];
  logic [2:0]       dv_neg_q  [1:DIV_STEPS];
  logic             dv_zero_q [1:DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [31:0]      rin;
    logic [32:0]      qin;
    logic [31:0]      lin;
    logic [2:0][29:0] scin;
    logic [2:0]       negin;
    logic             zin;
    logic [32:0]      shv;
    logic             ge;
    if (j == 0) begin : g_first
      assign rin   = 32'd1 << 28;
      assign qin   = 33'd0;
      assign lin   = sq_res_q[SQRT_STEPS][31:0];
      assign scin  = sq_sc_q[SQRT_STEPS];
      assign negin = sq_neg_q[SQRT_STEPS];
      assign zin   = sq_zero_q[SQRT_STEPS];
    end else begin : g_next
      assign rin   = dv_rem_q[j];
      assign qin   = dv_quo_q[j];
      assign lin   = dv_len_q[j];
      assign scin  = dv_sc_q[j];
      assign negin = dv_neg_q[j];
      assign zin   = dv_zero_q[j];
    end
    assign shv = {rin, 1'b0};
    assign ge  = shv >= {1'b0, lin};
    always_ff @(posedge clk_i) begin
      dv_rem_q[j+1]  <= ge ? 32'(shv - {1'b0, lin}) : shv[31:0];
      dv_quo_q[j+1]  <= {qin[31:0], ge};
      dv_len_q[j+1]  <= lin;
      dv_sc_q[j+1]   <= scin;
      dv_neg_q[j+1]  <= negin;
      dv_zero_q[j+1] <= zin;
    end
  end

  // unit components with sign, zero vector stays zero
  logic [2:0][62:0] prod;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = 63'(dv_sc_q[DIV_STEPS][i]) * 63'(dv_quo_q[DIV_STEPS]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_q[DIV_STEPS]) unit_o[i] <= 32'd0;
      else if (dv_neg_q[DIV_STEPS][i]) unit_o[i] <= 32'(-{1'b0, prod[i][61:31]});
      else unit_o[i] <= {1'b0, prod[i][61:31]};
    end
  end

endmodule

// ===== rtl/vprc_front.sv =====
// front: intake, extent check, directions, offsets, points and depth
module vprc_front import vprc_pkg::*; #(
  parameter int unsigned QDEPTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  in_t    in_data_i,
  output logic   push_o,
  output entry_t push_data_o,
  input  logic   pop_i
);

  localparam int unsigned CW = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic             bad;
    logic [2:0][47:0] anc;
    logic [2:0][47:0] ext;
  } pay_t;

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [47:0] sat48(logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_7FFF_FFFF_FFFF;
    lo = -50'sh0_8000_0000_0000;
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

  // credits: items in flight plus queued never exceed the queue depth
  logic [CW-1:0] cred_q;
  logic          acc;
  assign in_stall_o = (cred_q == CW'(QDEPTH));
  assign acc        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_q + CW'(acc) - CW'(pop_i);
    end
  end

  // stage 0: intake
  logic f0_v_q;
  in_t  f0_q;
  logic f0_bad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f0_v_q <= 1'b0;
    else f0_v_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    if (acc) begin
      f0_q     <= in_data_i;
      f0_bad_q <= (in_data_i.horizontal_extent <= 48'sd0) ||
                  (in_data_i.extent_above <= 48'sd0) ||
                  (in_data_i.extent_below <= 48'sd0);
    end
  end

  // stage 1: magnitudes and products of the normal
  logic [31:0] ax, ay, az;
  assign ax = abs32(f0_q.normal_x);
  assign ay = abs32(f0_q.normal_y);
  assign az = abs32(f0_q.normal_z);

  logic        f1_v_q;
  pay_t        f1_pay_q;
  logic [31:0] f1_ax_q, f1_ay_q;
  logic        f1_sx_q, f1_sy_q, f1_sz_q;
  logic [63:0] f1_pxz_q, f1_pyz_q, f1_pxx_q, f1_pyy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f1_v_q <= 1'b0;
    else f1_v_q <= f0_v_q;
  end
  always_ff @(posedge clk_i) begin
    f1_pay_q.bad <= f0_bad_q;
    f1_pay_q.anc <= {f0_q.anchor_z, f0_q.anchor_y, f0_q.anchor_x};
    f1_pay_q.ext <= {f0_q.extent_below, f0_q.extent_above, f0_q.horizontal_extent};
    f1_ax_q  <= ax;
    f1_ay_q  <= ay;
    f1_sx_q  <= f0_q.normal_x[31];
    f1_sy_q  <= f0_q.normal_y[31];
    f1_sz_q  <= f0_q.normal_z[31];
    f1_pxz_q <= 64'(ax) * 64'(az);
    f1_pyz_q <= 64'(ay) * 64'(az);
    f1_pxx_q <= 64'(ax) * 64'(ax);
    f1_pyy_q <= 64'(ay) * 64'(ay);
  end

  // horizontal = (ny, -nx, 0), up = (nx*nz, ny*nz, -(nx^2+ny^2))
  logic [2:0][63:0] hmag, umag;
  logic [2:0]       hneg, uneg;
  assign hmag = {64'd0, 64'(f1_ax_q), 64'(f1_ay_q)};
  assign hneg = {1'b0, !f1_sx_q, f1_sy_q};
  assign umag = {f1_pxx_q + f1_pyy_q, f1_pyz_q, f1_pxz_q};
  assign uneg = {1'b1, f1_sy_q ^ f1_sz_q, f1_sx_q ^ f1_sz_q};

  logic [2:0][31:0] hor, up;

  vprc_norm u_norm_hor (
    .clk_i  (clk_i),
    .mag_i  (hmag),
    .neg_i  (hneg),
    .unit_o (hor)
  );

  vprc_norm u_norm_up (
    .clk_i  (clk_i),
    .mag_i  (umag),
    .neg_i  (uneg),
    .unit_o (up)
  );

  // item data waits alongside the normalizers
  logic dl_v_q   [NORM_LAT];
  pay_t dl_pay_q [NORM_LAT];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NORM_LAT; k++) dl_v_q[k] <= 1'b0;
    end else begin
      dl_v_q[0] <= f1_v_q;
      for (int k = 1; k < NORM_LAT; k++) dl_v_q[k] <= dl_v_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    dl_pay_q[0] <= f1_pay_q;
    for (int k = 1; k < NORM_LAT; k++) dl_pay_q[k] <= dl_pay_q[k-1];
  end

  // stage 3: partial products of the offsets, per axis hh, ua, ub
  logic [30:0] mu  [9];
  logic [46:0] ev  [9];
  logic        sgn [9];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mu[3*i]    = hor[i][31] ? 31'(-hor[i]) : hor[i][30:0];
      sgn[3*i]   = hor[i][31];
      ev[3*i]    = dl_pay_q[NORM_LAT-1].ext[0][46:0];
      for (int t = 1; t < 3; t++) begin
        mu[3*i+t]  = up[i][31] ? 31'(-up[i]) : up[i][30:0];
        sgn[3*i+t] = up[i][31];
        ev[3*i+t]  = dl_pay_q[NORM_LAT-1].ext[t][46:0];
      end
    end
  end

  logic        f3_v_q;
  pay_t        f3_pay_q;
  logic [53:0] f3_phi_q [9];
  logic [54:0] f3_plo_q [9];
  logic        f3_neg_q [9];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f3_v_q <= 1'b0;
    else f3_v_q <= dl_v_q[NORM_LAT-1];
  end
  always_ff @(posedge clk_i) begin
    f3_pay_q <= dl_pay_q[NORM_LAT-1];
    for (int o = 0; o < 9; o++) begin
      f3_phi_q[o] <= 54'(mu[o]) * 54'(ev[o][46:24]);
      f3_plo_q[o] <= 55'(mu[o]) * 55'(ev[o][23:0]);
      f3_neg_q[o] <= sgn[o];
    end
  end

  // stage 4: combine partial products, truncate, apply sign
  logic [48:0] off [9];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int t = 0; t < 3; t++) begin
        logic [55:0] lo;
        logic [55:0] mag;
        int          kk;
        int          dd;
        kk  = (t == 0) ? 31 : 30;
        dd  = kk - 24;
        lo  = (({2'b0, f3_phi_q[3*i+t]} & ((56'd1 << dd) - 56'd1)) << 24) +
              {1'b0, f3_plo_q[3*i+t]};
        mag = ({2'b0, f3_phi_q[3*i+t]} >> dd) + (lo >> kk);
        off[3*i+t] = f3_neg_q[3*i+t] ? 49'(-{1'b0, mag[47:0]}) : {1'b0, mag[47:0]};
      end
    end
  end

  logic        f4_v_q;
  pay_t        f4_pay_q;
  logic [48:0] f4_off_q [9];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f4_v_q <= 1'b0;
    else f4_v_q <= f3_v_q;
  end
  always_ff @(posedge clk_i) begin
    f4_pay_q <= f3_pay_q;
    for (int o = 0; o < 9; o++) f4_off_q[o] <= off[o];
  end

  // stage 5: point sums with saturation
  logic [NPTS-1:0][2:0][47:0] pts;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [49:0] av, hh, ua, ub;
      av = $signed({{2{f4_pay_q.anc[i][47]}}, f4_pay_q.anc[i]});
      hh = $signed({f4_off_q[3*i][48], f4_off_q[3*i]});
      ua = $signed({f4_off_q[3*i+1][48], f4_off_q[3*i+1]});
      ub = $signed({f4_off_q[3*i+2][48], f4_off_q[3*i+2]});
      pts[KIND_C0][i]  = sat48(av + hh - ua);
      pts[KIND_C1][i]  = sat48(av + hh + ub);
      pts[KIND_C2][i]  = sat48(av - hh + ub);
      pts[KIND_C3][i]  = sat48(av - hh - ua);
      pts[KIND_TOP][i] = sat48(av - ua);
      pts[KIND_BOT][i] = sat48(av + ub);
    end
  end

  logic                       f5_v_q;
  logic                       f5_bad_q;
  logic [NPTS-1:0][2:0][47:0] f5_pts_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f5_v_q <= 1'b0;
    else f5_v_q <= f4_v_q;
  end
  always_ff @(posedge clk_i) begin
    f5_bad_q <= f4_pay_q.bad;
    f5_pts_q <= pts;
  end

  // stage 6: largest absolute corner depth, entry out to the queue
  logic [46:0] depth;
  always_comb begin
    depth = 47'd0;
    for (int k = 0; k < 4; k++) begin
      logic [47:0] zabs;
      logic [46:0] zc;
      zabs = f5_pts_q[k][2][47] ? 48'(-f5_pts_q[k][2]) : f5_pts_q[k][2];
      zc   = zabs[47] ? {47{1'b1}} : zabs[46:0];
      if (zc > depth) depth = zc;
    end
  end

  logic f6_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f6_v_q <= 1'b0;
    else f6_v_q <= f5_v_q;
  end
  always_ff @(posedge clk_i) begin
    push_data_o.bad   <= f5_bad_q;
    push_data_o.depth <= depth;
    for (int k = 0; k < NPTS; k++) begin
      push_data_o.px[k] <= f5_pts_q[k][0];
      push_data_o.py[k] <= f5_pts_q[k][1];
      push_data_o.pz[k] <= f5_pts_q[k][2];
    end
  end
  assign push_o = f6_v_q;

endmodule

// ===== rtl/vprc_queue.sv =====
// queue of finished items between front and back
module vprc_queue import vprc_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output logic   avail_o,
  output entry_t head_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= push_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign avail_o = (cnt_q != '0);
  assign head_o  = mem[rd_q];

endmodule

// ===== rtl/vprc_back.sv =====
// back: walks one item's results out through the output register
module vprc_back import vprc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   avail_i,
  input  entry_t head_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output out_t   out_data_o
);

  logic       busy_q;
  entry_t     cur_q;
  logic [2:0] idx_q;
  logic       load_out, fin;
  out_t       res;

  assign load_out = busy_q && (!out_valid_o || !out_stall_i);
  assign fin      = load_out && (cur_q.bad || idx_q == KIND_BOT);
  assign pop_o    = avail_i && (!busy_q || fin);

  // result for the current index, a single zero result when invalid
  always_comb begin
    if (cur_q.bad) begin
      res = '0;
      res.point_kind = KIND_C0;
      res.last       = 1'b1;
    end else begin
      res.point_kind = idx_q;
      res.point_x    = cur_q.px[idx_q];
      res.point_y    = cur_q.py[idx_q];
      res.point_z    = cur_q.pz[idx_q];
      res.valid_res  = 1'b1;
      res.max_depth  = cur_q.depth;
      res.last       = (idx_q == KIND_BOT);
    end
  end

  // sequencing and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= KIND_C0;
      out_valid_o <= 1'b0;
    end else begin
      if (load_out) idx_q <= idx_q + 3'd1;
      if (fin) busy_q <= 1'b0;
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= KIND_C0;
      end
      if (load_out) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (load_out) out_data_o <= res;
  end

endmodule

// ===== rtl/vertical_plane_rectangle_corners.sv =====
// top level of the vertical plane rectangle corner block
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | in_data_i (in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//
// a valid item gives six results, one per cycle while the output is not stalled;
// an item with a non-positive extent gives one result.
// the path from a transfer in to its first result runs through the
// square root and reciprocal stages of the direction normalizers.
// front intake is credited by QDEPTH and a credit comes back when the back
// pops the item from the queue, so up to QDEPTH items are in flight or queued.
// reset clears all control state.
// a stall on the output only stops the back; the front fills the queue.
module vertical_plane_rectangle_corners import vprc_pkg::*; #(
  parameter int unsigned QDEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic   push, pop, avail;
  entry_t push_data, head;

  vprc_front #(.QDEPTH(QDEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .pop_i       (pop)
  );

  vprc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .avail_o     (avail),
    .head_o      (head)
  );

  vprc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/vprc_checker.sv =====
// port checker of the vertical plane rectangle corner block and its bind
module vprc_checker import vprc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled input transfer stays offered with the same payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // an invalid result closes its item, with kind C0, zero depth and zero z
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |->
      out_data_o.last && out_data_o.point_kind == KIND_C0 &&
      out_data_o.max_depth == 47'd0 && out_data_o.point_z == 48'sd0)
    else $error("invalid result not a zero closing result");

  // the bottom intersect closes a valid item and nothing else does
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res |->
      out_data_o.last == (out_data_o.point_kind == KIND_BOT))
    else $error("last flag does not match point kind");

endmodule

bind vertical_plane_rectangle_corners vprc_checker u_vprc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
